### hdl/assert_macros.svh
// Assertion helpers shared by the RTL. Both expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define JSU_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// Next-cycle implication.
`define JSU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`endif

### hdl/jsu_pkg.sv
`default_nettype none
package jsu_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } jsu_in_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic [1:0] status;
  } jsu_out_t;

  localparam logic [1:0] ST_CHAR  = 2'd0;
  localparam logic [1:0] ST_END   = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_FF     = 8'h0c;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  typedef enum logic [2:0] {
    CLS_PLAIN,
    CLS_ZERO,
    CLS_QUOTE,
    CLS_BSLASH,
    CLS_CTRL
  } jsu_cls_t;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_BODY = 3'd1,
    MODE_ESC  = 3'd2,
    MODE_HEX1 = 3'd3,
    MODE_HEX2 = 3'd4,
    MODE_HEX3 = 3'd5,
    MODE_HEX4 = 3'd6
  } jsu_mode_t;

  // One classified byte, as queued between front and back.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    jsu_cls_t   cls;
    logic       esc_hit;
    logic [7:0] esc_char;
    logic       esc_u;
    logic       hex_hit;
    logic [3:0] hex_val;
  } jsu_item_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] ch;
  } jsu_esc_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] val;
  } jsu_hex_t;

  function automatic jsu_esc_t esc_map(input logic [7:0] b);
    jsu_esc_t r;
    r.hit = 1'b1;
    unique case (b)
      CH_QUOTE:  r.ch = CH_QUOTE;
      CH_BSLASH: r.ch = CH_BSLASH;
      CH_SLASH:  r.ch = CH_SLASH;
      8'h62:     r.ch = CH_BS;   // b
      8'h66:     r.ch = CH_FF;   // f
      8'h6e:     r.ch = CH_LF;   // n
      8'h72:     r.ch = CH_CR;   // r
      8'h74:     r.ch = CH_TAB;  // t
      default: begin
        r.hit = 1'b0;
        r.ch  = 8'h00;
      end
    endcase
    return r;
  endfunction

  function automatic jsu_hex_t hex_map(input logic [7:0] b);
    jsu_hex_t r;
    r.hit = 1'b1;
    r.val = 4'h0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r.val = b[3:0];
    end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
      r.val = b[3:0] + 4'd9;
    end else begin
      r.hit = 1'b0;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### hdl/jsu_front.sv
`default_nettype none
// Classifies one incoming byte for the back end.
module jsu_front (
  input  wire jsu_pkg::jsu_in_t   in_item,
  output jsu_pkg::jsu_item_t      cls_item
);

  jsu_pkg::jsu_esc_t esc;
  jsu_pkg::jsu_hex_t hex;

  assign esc = jsu_pkg::esc_map(in_item.data_byte);
  assign hex = jsu_pkg::hex_map(in_item.data_byte);

  always_comb begin
    cls_item.data_byte  = in_item.data_byte;
    cls_item.first_byte = in_item.first_byte;
    cls_item.esc_hit    = esc.hit;
    cls_item.esc_char   = esc.ch;
    cls_item.esc_u      = (in_item.data_byte == 8'h75);  // u
    cls_item.hex_hit    = hex.hit;
    cls_item.hex_val    = hex.val;
    priority if (in_item.data_byte == 8'h00) begin
      cls_item.cls = jsu_pkg::CLS_ZERO;
    end else if (in_item.data_byte == jsu_pkg::CH_BSLASH) begin
      cls_item.cls = jsu_pkg::CLS_BSLASH;
    end else if (in_item.data_byte == jsu_pkg::CH_QUOTE) begin
      cls_item.cls = jsu_pkg::CLS_QUOTE;
    end else if (in_item.data_byte < jsu_pkg::CH_SPACE &&
                 in_item.data_byte != jsu_pkg::CH_TAB) begin
      cls_item.cls = jsu_pkg::CLS_CTRL;
    end else begin
      cls_item.cls = jsu_pkg::CLS_PLAIN;
    end
  end

endmodule
`default_nettype wire

### hdl/jsu_fifo.sv
`default_nettype none
`include "assert_macros.svh"
// Small register queue between front and back.
module jsu_fifo #(
  parameter int DEPTH = 2
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       push,
  input  wire jsu_pkg::jsu_item_t   push_item,
  output logic                      full,
  input  wire                       pop,
  output jsu_pkg::jsu_item_t        pop_item,
  output logic                      not_empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  jsu_pkg::jsu_item_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  `JSU_ASSERT_SAME(a_no_overflow, push, !full)
  `JSU_ASSERT_SAME(a_no_underflow, pop, not_empty)

endmodule
`default_nettype wire

### hdl/jsu_back.sv
`default_nettype none
`include "assert_macros.svh"
// Escape state machine and output register.
module jsu_back (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       item_avail,
  input  wire jsu_pkg::jsu_item_t   item,
  output logic                      pop,
  output logic                      out_valid,
  input  wire                       out_ready,
  output jsu_pkg::jsu_out_t         out_data
);

  jsu_pkg::jsu_mode_t mode_r, mode_nxt, mode_eff;
  // Last hex digit; with the fourth digit it forms the low byte of the value.
  logic [3:0]         hex_r, hex_nxt;
  logic               out_valid_r;
  jsu_pkg::jsu_out_t  out_data_r;
  logic               res_hit;
  jsu_pkg::jsu_out_t  res;

  assign pop       = item_avail && (!out_valid_r || out_ready);
  assign mode_eff  = item.first_byte ? jsu_pkg::MODE_BODY : mode_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Next state
  always_comb begin
    mode_nxt = mode_r;
    hex_nxt  = hex_r;
    if (pop) begin
      if (item.first_byte) begin
        hex_nxt = 4'h0;
      end
      unique case (mode_eff)
        jsu_pkg::MODE_BODY: begin
          unique case (item.cls)
            jsu_pkg::CLS_PLAIN:  mode_nxt = jsu_pkg::MODE_BODY;
            jsu_pkg::CLS_BSLASH: mode_nxt = jsu_pkg::MODE_ESC;
            default:             mode_nxt = jsu_pkg::MODE_IDLE;
          endcase
        end
        jsu_pkg::MODE_ESC: begin
          if (item.esc_u) begin
            mode_nxt = jsu_pkg::MODE_HEX1;
            hex_nxt  = 4'h0;
          end else if (item.esc_hit) begin
            mode_nxt = jsu_pkg::MODE_BODY;
          end else begin
            mode_nxt = jsu_pkg::MODE_IDLE;
          end
        end
        jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2, jsu_pkg::MODE_HEX3,
        jsu_pkg::MODE_HEX4: begin
          if (item.hex_hit) begin
            hex_nxt  = item.hex_val;
            mode_nxt = (mode_eff == jsu_pkg::MODE_HEX4) ? jsu_pkg::MODE_BODY
                                                        : jsu_pkg::jsu_mode_t'(mode_eff + 3'd1);
          end else begin
            mode_nxt = jsu_pkg::MODE_IDLE;
          end
        end
        default: mode_nxt = jsu_pkg::MODE_IDLE;
      endcase
    end
  end

  // Result for the item being popped
  always_comb begin
    res_hit      = 1'b0;
    res.char_out = 8'h00;
    res.status   = jsu_pkg::ST_CHAR;
    unique case (mode_eff)
      jsu_pkg::MODE_BODY: begin
        res_hit = (item.cls != jsu_pkg::CLS_BSLASH);
        unique case (item.cls)
          jsu_pkg::CLS_PLAIN: res.char_out = item.data_byte;
          jsu_pkg::CLS_QUOTE: res.status   = jsu_pkg::ST_END;
          jsu_pkg::CLS_ZERO,
          jsu_pkg::CLS_CTRL:  res.status   = jsu_pkg::ST_ERROR;
          default:            res.status   = jsu_pkg::ST_CHAR;
        endcase
      end
      jsu_pkg::MODE_ESC: begin
        res_hit = !item.esc_u;
        if (item.esc_hit) begin
          res.char_out = item.esc_char;
        end else begin
          res.status = jsu_pkg::ST_ERROR;
        end
      end
      jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2, jsu_pkg::MODE_HEX3: begin
        res_hit    = !item.hex_hit;
        res.status = jsu_pkg::ST_ERROR;
      end
      jsu_pkg::MODE_HEX4: begin
        res_hit = 1'b1;
        if (item.hex_hit) begin
          res.char_out = {hex_r, item.hex_val};
        end else begin
          res.status = jsu_pkg::ST_ERROR;
        end
      end
      default: res_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= jsu_pkg::MODE_IDLE;
      hex_r       <= 4'h0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      hex_r  <= hex_nxt;
      if (pop) begin
        out_valid_r <= res_hit;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && res_hit) begin
      out_data_r <= res;
    end
  end

  `JSU_ASSERT_SAME(a_status_legal, out_valid_r, out_data_r.status != 2'd3)
  `JSU_ASSERT_SAME(a_nonchar_zero,
                   out_valid_r && out_data_r.status != jsu_pkg::ST_CHAR,
                   out_data_r.char_out == 8'h00)
  `JSU_ASSERT_NEXT(a_idle_after_stop,
                   pop && res_hit && res.status != jsu_pkg::ST_CHAR,
                   mode_r == jsu_pkg::MODE_IDLE)

endmodule
`default_nettype wire

### hdl/json_string_unescape.sv
`default_nettype none
// JSON string body unescaper. Feed the bytes that follow the opening quote,
// one per item, with first_byte set on the first of each string; that byte
// drops any parse in progress. Each item gives zero or one result: a decoded
// character (status 0), end of string at the unescaped closing quote
// (status 1), or an error (status 2) for a zero byte, a raw control byte
// other than tab, an unknown escape letter or a bad hex digit. A \u escape
// yields the low 8 bits of its four hex digits. A backslash, and the u and
// the first three hex digits of a \u escape, give no result. After an end or
// an error, bytes are dropped until the next first_byte. The block takes one
// byte per clock sustained while out_ready is high. A byte is registered in
// the classify queue, then the escape state machine loads its result into the
// output register that drives out_valid; a result that waits for out_ready
// holds later bytes in the queue. The queue between the byte classifier and
// the escape state machine is QDEPTH entries deep, so while a result waits
// for out_ready the input still takes up to QDEPTH more bytes before
// in_ready drops.
module json_string_unescape #(
  parameter int QDEPTH = 2
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       in_valid,
  output logic                      in_ready,
  input  wire jsu_pkg::jsu_in_t     in_data,
  output logic                      out_valid,
  input  wire                       out_ready,
  output jsu_pkg::jsu_out_t         out_data
);

  jsu_pkg::jsu_item_t cls_item;
  jsu_pkg::jsu_item_t q_item;
  logic               q_full;
  logic               q_avail;
  logic               q_pop;
  logic               q_push;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // Front: byte classification (escape letter, hex digit, control byte)
  jsu_front u_front (
    .in_item  (in_data),
    .cls_item (cls_item)
  );

  // Queue between front and back
  jsu_fifo #(
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (cls_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_item),
    .not_empty (q_avail)
  );

  // Back: escape state machine, result register
  jsu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_avail (q_avail),
    .item       (q_item),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
`default_nettype wire

### dv/tb_top.sv
`timescale 1ns / 1ps

// Predictor and store of expected characters for the unescaper. The predictor
// tracks the parse mode and the \u accumulator; every byte the block accepts
// is fed to take_byte in acceptance order, and results are matched in order.
class unescape_model;
  jsu_pkg::jsu_mode_t mode;
  logic [7:0]         hex_acc;
  jsu_pkg::jsu_out_t  pending[$];
  int                 errors;

  function new();
    mode    = jsu_pkg::MODE_IDLE;
    hex_acc = 8'h00;
    errors  = 0;
  endfunction

  // End and error both drop the parse back to idle.
  function void queue_result(input logic [7:0] ch, input logic [1:0] st);
    jsu_pkg::jsu_out_t r;
    r.char_out = ch;
    r.status   = st;
    pending = {pending, r};
    if (st != jsu_pkg::ST_CHAR) mode = jsu_pkg::MODE_IDLE;
  endfunction

  // Returns 0 when the byte is dropped (idle, no first_byte).
  function bit take_byte(input jsu_pkg::jsu_in_t item);
    logic [7:0] b;
    logic [3:0] nib;
    bit         is_hex;
    b = item.data_byte;
    if (item.first_byte) begin
      mode    = jsu_pkg::MODE_BODY;
      hex_acc = 8'h00;
    end
    case (mode)
      jsu_pkg::MODE_BODY: begin
        if (b < jsu_pkg::CH_SPACE && b != jsu_pkg::CH_TAB) queue_result(8'h00, jsu_pkg::ST_ERROR);
        else if (b == jsu_pkg::CH_BSLASH) mode = jsu_pkg::MODE_ESC;
        else if (b == jsu_pkg::CH_QUOTE) queue_result(8'h00, jsu_pkg::ST_END);
        else queue_result(b, jsu_pkg::ST_CHAR);
      end
      jsu_pkg::MODE_ESC: begin
        mode = jsu_pkg::MODE_BODY;
        case (b)
          jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH:
            queue_result(b, jsu_pkg::ST_CHAR);
          "b": queue_result(jsu_pkg::CH_BS, jsu_pkg::ST_CHAR);
          "f": queue_result(jsu_pkg::CH_FF, jsu_pkg::ST_CHAR);
          "n": queue_result(jsu_pkg::CH_LF, jsu_pkg::ST_CHAR);
          "r": queue_result(jsu_pkg::CH_CR, jsu_pkg::ST_CHAR);
          "t": queue_result(jsu_pkg::CH_TAB, jsu_pkg::ST_CHAR);
          "u": begin
            hex_acc = 8'h00;
            mode    = jsu_pkg::MODE_HEX1;
          end
          default: queue_result(8'h00, jsu_pkg::ST_ERROR);
        endcase
      end
      jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2, jsu_pkg::MODE_HEX3, jsu_pkg::MODE_HEX4: begin
        is_hex = 1'b1;
        nib    = 4'h0;
        if (b >= "0" && b <= "9") nib = 4'(b - "0");
        else if (b >= "A" && b <= "F") nib = 4'(b - "A" + 8'd10);
        else if (b >= "a" && b <= "f") nib = 4'(b - "a" + 8'd10);
        else is_hex = 1'b0;
        if (!is_hex) begin
          queue_result(8'h00, jsu_pkg::ST_ERROR);
        end else begin
          // Only the low byte of the code point survives.
          hex_acc = {hex_acc[3:0], nib};
          if (mode == jsu_pkg::MODE_HEX4) begin
            mode = jsu_pkg::MODE_BODY;
            queue_result(hex_acc, jsu_pkg::ST_CHAR);
          end else begin
            mode = jsu_pkg::jsu_mode_t'(mode + 3'd1);
          end
        end
      end
      default: begin
        mode = jsu_pkg::MODE_IDLE;
        return 1'b0;
      end
    endcase
    return 1'b1;
  endfunction

  function void check_result(input jsu_pkg::jsu_out_t got);
    jsu_pkg::jsu_out_t want;
    if (pending.size() == 0) begin
      $error("result with nothing expected: char_out=%h status=%0d",
             got.char_out, got.status);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (got.char_out !== want.char_out) begin
      $error("char_out: expected %h, got %h", want.char_out, got.char_out);
      errors++;
    end
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      errors++;
    end
  endfunction
endclass

module tb_top;

  // Roughly 650 bytes that the block actually parses (dropped bytes excluded).
  localparam int ITEM_TARGET = 650;
  // Run-length limit, with ample margin over a normal run.
  localparam int CYCLE_LIMIT = 200000;
  // Long receiver hold-off, long enough to back the queue up into the input.
  localparam int HOLD_CYCLES = 80;
  // Settle time at the end, after the last expected result has come back.
  localparam int SETTLE_CYCLES = 8;

  // The eight single-letter escapes, as they appear after the backslash.
  localparam logic [7:0] ESC_LETTERS [8] = '{jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH,
                                             jsu_pkg::CH_SLASH,
                                             "b", "f", "n", "r", "t"};

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  jsu_pkg::jsu_in_t  in_data;
  logic              out_valid;
  logic              out_ready;
  jsu_pkg::jsu_out_t out_data;

  json_string_unescape u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  unescape_model model = new();

  jsu_pkg::jsu_in_t str_q[$];     // bytes of the string being sent
  int               burst_left;   // items left in the current sender burst
  int               live_items;   // accepted items the parser acted on
  bit               hold_req;     // asks the receiver for one long hold-off
  int               cycle_count;

  initial begin
    clk = 1'b0;
  end

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Offer one item and hold it until accepted. Between bursts valid drops
  // for a random gap; a gap of zero keeps valid high straight through.
  task automatic offer(input jsu_pkg::jsu_in_t item);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      // Now and then a long burst with no idling at all.
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    if (model.take_byte(item)) live_items++;
    burst_left--;
  endtask

  task automatic put(input logic [7:0] b, input logic first);
    jsu_pkg::jsu_in_t it;
    it.data_byte  = b;
    it.first_byte = first;
    offer(it);
  endtask

  // Stop sending until every expected result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (model.pending.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // String generator
  // ---------------------------------------------------------------------------

  task automatic add(input logic [7:0] b);
    jsu_pkg::jsu_in_t it;
    it.data_byte  = b;
    it.first_byte = 1'b0;
    str_q = {str_q, it};
  endtask

  // Printable ASCII other than quote and backslash, high bytes, and tab.
  function automatic logic [7:0] rand_plain();
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0, 1:    b = 8'($urandom_range(128, 255));
      2:       b = jsu_pkg::CH_TAB;
      default: begin
        b = 8'($urandom_range(32, 126));
        if (b == jsu_pkg::CH_QUOTE || b == jsu_pkg::CH_BSLASH) b = b + 8'd1;
      end
    endcase
    return b;
  endfunction

  function automatic logic [7:0] rand_hex_char();
    logic [7:0] v;
    v = 8'($urandom_range(0, 15));
    if (v < 8'd10) return "0" + v;
    return (($urandom_range(0, 1) == 0) ? "a" : "A") + v - 8'd10;
  endfunction

  // Anything outside 0-9, A-F, a-f, zero included.
  function automatic logic [7:0] rand_non_hex();
    case ($urandom_range(0, 3))
      0:       return 8'($urandom_range(8'h00, 8'h2f));
      1:       return 8'($urandom_range(8'h3a, 8'h40));
      2:       return 8'($urandom_range(8'h47, 8'h60));
      default: return 8'($urandom_range(8'h67, 8'hff));
    endcase
  endfunction

  task automatic add_good_token();
    case ($urandom_range(0, 9))
      5, 6, 7: begin
        add(jsu_pkg::CH_BSLASH);
        add(ESC_LETTERS[$urandom_range(0, 7)]);
      end
      8, 9: begin
        add(jsu_pkg::CH_BSLASH);
        add("u");
        repeat (4) add(rand_hex_char());
      end
      default: add(rand_plain());
    endcase
  endtask

  task automatic add_bad_token();
    logic [7:0] b;
    case ($urandom_range(0, 3))
      0: add(8'h00);
      1: begin
        // raw control byte; tab is legal so swap it for a newline
        b = 8'($urandom_range(1, 31));
        if (b == jsu_pkg::CH_TAB) b = jsu_pkg::CH_LF;
        add(b);
      end
      2: begin
        b = 8'($urandom_range(0, 255));
        if (b inside {jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH,
                      "b", "f", "n", "r", "t", "u"})
          b = "x";
        add(jsu_pkg::CH_BSLASH);
        add(b);
      end
      default: begin
        // bad digit at a random position of the \u escape
        add(jsu_pkg::CH_BSLASH);
        add("u");
        repeat ($urandom_range(0, 3)) add(rand_hex_char());
        add(rand_non_hex());
      end
    endcase
  endtask

  // Mostly well-formed strings with random content and a closing quote.
  // About one in five carries an error, one in ten is cut short (possibly in
  // the middle of an escape) so the next first byte restarts the parse, and
  // some are followed by stray bytes, dropped when the parser is idle.
  task automatic build_string();
    int               n;
    int               bad_at;
    bit               truncate;
    jsu_pkg::jsu_in_t head;
    str_q.delete();
    n        = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
    bad_at   = ($urandom_range(0, 4) == 0) ? $urandom_range(0, n) : -1;
    truncate = ($urandom_range(0, 9) == 0);
    for (int i = 0; i < n; i++) begin
      if (i == bad_at) add_bad_token();
      add_good_token();
    end
    if (bad_at == n) add_bad_token();
    if (truncate) begin
      repeat ($urandom_range(0, 2)) if (str_q.size() > 1) void'(str_q.pop_back());
    end else begin
      add(jsu_pkg::CH_QUOTE);
    end
    if (str_q.size() == 0) add(rand_plain());
    head            = str_q[0];
    head.first_byte = 1'b1;
    str_q[0]        = head;
    if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3)) add(8'($urandom_range(0, 255)));
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: a random stall style, redrawn at regular intervals; on request,
  // one long hold-off so the internal queue fills and in_ready drops.
  // ---------------------------------------------------------------------------
  initial begin
    int style;
    int cyc;
    style     = 0;
    cyc       = 0;
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) model.check_result(out_data);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      if (cyc % 64 == 0) style = $urandom_range(0, 4);
      case (style)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 1) == 0);
        2: out_ready <= ($urandom_range(0, 7) != 0);
        3: out_ready <= ((cyc % 5) != 0);
        default: out_ready <= ((cyc % 16) >= 4);
      endcase
      cyc++;
    end
  end

  // Run-length guard.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("json_string_unescape: mismatch");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int strings_done;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    hold_req   = 1'b0;
    burst_left = 0;
    live_items = 0;
    strings_done = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: a byte in idle is dropped.
    put("A", 1'b0);
    // Plain bytes: space, top and bottom of the high range, tab.
    put(jsu_pkg::CH_SPACE, 1'b1);
    put(8'hff, 1'b0);
    put(8'h80, 1'b0);
    put(jsu_pkg::CH_TAB, 1'b0);
    // \u0000 decodes to a zero character, not an error.
    put(jsu_pkg::CH_BSLASH, 1'b0);
    put("u", 1'b0);
    repeat (4) put("0", 1'b0);
    // Mixed-case hex digits; only the low byte 0xAB comes out.
    put(jsu_pkg::CH_BSLASH, 1'b0);
    put("u", 1'b0);
    put("F", 1'b0);
    put("f", 1'b0);
    put("a", 1'b0);
    put("B", 1'b0);
    put(jsu_pkg::CH_BSLASH, 1'b0);
    put("n", 1'b0);
    put(jsu_pkg::CH_QUOTE, 1'b0);
    // After the end, bytes are dropped.
    put("x", 1'b0);
    // Zero byte, unknown escape letter, bad hex digit, raw control byte,
    // zero byte inside an escape.
    put(8'h00, 1'b1);
    put(jsu_pkg::CH_BSLASH, 1'b1);
    put("q", 1'b0);
    put(jsu_pkg::CH_BSLASH, 1'b1);
    put("u", 1'b0);
    put("9", 1'b0);
    put("G", 1'b0);
    put(8'h1f, 1'b1);
    put(jsu_pkg::CH_BSLASH, 1'b1);
    put(8'h00, 1'b0);
    // first_byte in the middle of a \u escape restarts the parse.
    put(8'h7f, 1'b1);
    put(jsu_pkg::CH_BSLASH, 1'b0);
    put("u", 1'b0);
    put("1", 1'b1);
    put(jsu_pkg::CH_QUOTE, 1'b0);
    wait_drained();

    // Random strings until enough parsed bytes have gone in.
    while (live_items < ITEM_TARGET) begin
      build_string();
      if (strings_done == 8 || strings_done == 70) hold_req = 1'b1;
      if (strings_done % 40 == 39) wait_drained();
      foreach (str_q[i]) offer(str_q[i]);
      strings_done++;
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (model.errors == 0 && model.pending.size() == 0) begin
      $display("json_string_unescape: match");
    end else begin
      $display("json_string_unescape: mismatch");
    end
    $finish;
  end

endmodule
